[sv/frds_pkg.sv]
// ----------------------------------------------------------------------------
// frds_pkg
// Shared types and constants for the FAT12 root directory search block.
// ----------------------------------------------------------------------------
package frds_pkg;

    // Directory layout
    localparam int unsigned ENTRY_BYTES        = 32;
    localparam int unsigned ENTRIES_PER_SECTOR = 16;
    localparam logic [7:0]  MARK_END           = 8'h00;
    localparam logic [7:0]  MARK_DELETED       = 8'hE5;
    localparam logic [4:0]  POS_LAST           = 5'(ENTRY_BYTES - 1);
    localparam logic [3:0]  BASE_MAX           = 4'd8;

    // Result status codes
    localparam logic [2:0] ST_NO_MATCH  = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_END       = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_NAME_BASE   = 2'd0;
    localparam logic [1:0] CFG_BASE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_EXT_BYTES   = 2'd2;
    localparam logic [1:0] CFG_ROOT_COUNT  = 2'd3;

    // Configuration reset values
    localparam logic [3:0]  BASE_LENGTH_RST = 4'd8;
    localparam logic [15:0] ROOT_COUNT_RST  = 16'd224;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] start_cluster;
        logic [31:0] file_size;
        logic [15:0] entry_index;
    } out_t;

    typedef struct packed {
        logic [63:0] name_base;
        logic [3:0]  base_length;
        logic [23:0] ext_bytes;
        logic [15:0] root_entry_count;
    } cfg_t;

endpackage

[sv/frds_scan.sv]
// ----------------------------------------------------------------------------
// frds_scan
// Per-byte entry scanner: tracks position in the current directory entry,
// compares name and extension bytes, captures cluster and size, and decides
// the entry outcome.
// ----------------------------------------------------------------------------
module frds_scan
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  frds_pkg::in_t  item,
    input  frds_pkg::cfg_t cfg,
    output logic           emit,
    output frds_pkg::out_t res
);
    import frds_pkg::*;

    logic [4:0]  byte_pos_reg, byte_pos_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  first_reg, first_next;
    logic        match_reg, match_next;
    logic [15:0] cluster_reg, cluster_next;
    logic [31:0] size_reg, size_next;
    logic        concl_reg, concl_next;

    // Current view of the state, with restart applied
    logic [4:0]  pos;
    logic [15:0] cnt;
    logic        concl;
    logic [15:0] limit;
    logic [3:0]  blen;
    logic [7:0]  b;
    logic [16:0] cnt_inc;

    assign b       = item.data_byte;
    assign pos     = item.restart ? 5'd0  : byte_pos_reg;
    assign cnt     = item.restart ? 16'd0 : cnt_reg;
    assign concl   = item.restart ? 1'b0  : concl_reg;
    assign limit   = {cfg.root_entry_count[15:4], 4'b0000};
    assign blen    = (cfg.base_length > BASE_MAX) ? BASE_MAX : cfg.base_length;
    assign cnt_inc = {1'b0, cnt} + 17'd1;

    // Step logic for one directory byte
    always_comb
    begin
        byte_pos_next = pos;
        cnt_next      = cnt;
        first_next    = first_reg;
        match_next    = match_reg;
        cluster_next  = cluster_reg;
        size_next     = size_reg;
        concl_next    = concl;
        emit          = 1'b0;
        res           = '0;
        res.entry_index = cnt;

        if (!concl)
        begin
            if (pos == 5'd0 && cnt >= limit)
            begin
                concl_next = 1'b1;
                emit       = 1'b1;
                res.status = ST_EXHAUSTED;
            end
            else if (pos == 5'd0 && b == MARK_END)
            begin
                concl_next = 1'b1;
                emit       = 1'b1;
                res.status = ST_END;
            end
            else
            begin
                // new entry starts fresh
                if (pos == 5'd0)
                begin
                    first_next   = b;
                    match_next   = 1'b1;
                    cluster_next = '0;
                    size_next    = '0;
                end

                // field compare and capture
                if (pos < 5'd8)
                begin
                    if ({1'b0, pos[3:0]} < {1'b0, blen}
                        && b != cfg.name_base[pos[2:0]*8 +: 8])
                    begin
                        match_next = 1'b0;
                    end
                end
                else if (pos inside {[5'd8:5'd10]})
                begin
                    if (b != cfg.ext_bytes[pos[1:0]*8 +: 8])
                    begin
                        match_next = 1'b0;
                    end
                end
                else if (pos == 5'd26)
                begin
                    cluster_next[7:0] = b;
                end
                else if (pos == 5'd27)
                begin
                    cluster_next[15:8] = b;
                end
                else if (pos >= 5'd28)
                begin
                    size_next[pos[1:0]*8 +: 8] = b;
                end

                // entry outcome on its last byte
                if (pos != POS_LAST)
                begin
                    byte_pos_next = pos + 5'd1;
                end
                else
                begin
                    byte_pos_next = 5'd0;
                    emit          = 1'b1;
                    if (first_next != MARK_DELETED && match_next)
                    begin
                        concl_next        = 1'b1;
                        res.status        = ST_FOUND;
                        res.start_cluster = cluster_next;
                        res.file_size     = size_next;
                    end
                    else if (cnt_inc >= {1'b0, limit})
                    begin
                        concl_next = 1'b1;
                        res.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        res.status = (first_next == MARK_DELETED) ? ST_DELETED
                                                                  : ST_NO_MATCH;
                        cnt_next   = cnt_inc[15:0];
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            cnt_reg      <= '0;
            first_reg    <= '0;
            match_reg    <= 1'b1;
            cluster_reg  <= '0;
            size_reg     <= '0;
            concl_reg    <= 1'b0;
        end
        else if (step)
        begin
            byte_pos_reg <= byte_pos_next;
            cnt_reg      <= cnt_next;
            first_reg    <= first_next;
            match_reg    <= match_next;
            cluster_reg  <= cluster_next;
            size_reg     <= size_next;
            concl_reg    <= concl_next;
        end
    end

    // A final outcome closes the search
    a_final_concludes: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && (res.status == ST_FOUND || res.status == ST_END
                         || res.status == ST_EXHAUSTED) |=> concl_reg)
        else $error("final outcome did not conclude the search");

    // Nothing comes out of a concluded search until restart
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        concl_reg && !item.restart |-> !emit)
        else $error("result after search concluded");

    // Cluster and size are only reported for a found entry
    a_payload_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        emit && res.status != ST_FOUND |-> res.start_cluster == 16'd0
                                           && res.file_size == 32'd0)
        else $error("payload on non-found result");

    // A skipped entry advances the entry counter and rewinds the position
    a_skip_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && (res.status == ST_NO_MATCH || res.status == ST_DELETED)
        |=> byte_pos_reg == 5'd0 && cnt_reg == $past(cnt) + 16'd1)
        else $error("entry counter did not advance");

endmodule

[sv/fat12_root_dir_search.sv]
// ----------------------------------------------------------------------------
// fat12_root_dir_search
// Searches a FAT12 root directory byte stream for a configured 8.3 name.
// ----------------------------------------------------------------------------
// Result path: the input transfer loads the input register, then a scan step
//   writes the outcome into the result register.
// Throughput: one directory byte per cycle; the scan state updates once per
//   accepted byte. Input stalls only while a result waits for result_ready.
// Reset: clears scan state and result valid; configuration returns to
//   name 0, base length 8, extension 0, root entry count 224.
module fat12_root_dir_search
(
    input  logic            clk,
    input  logic            rst_n,
    // directory byte channel
    input  logic            item_valid,
    output logic            item_ready,
    input  frds_pkg::in_t   item,
    // result channel
    output logic            result_valid,
    input  logic            result_ready,
    output frds_pkg::out_t  result,
    // configuration write channel
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    import frds_pkg::*;

    cfg_t cfg_reg;
    in_t  item_reg;
    logic item_valid_reg;
    logic result_valid_reg, result_valid_next;
    out_t result_reg;

    logic step;
    logic emit;
    out_t res;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.name_base        <= '0;
            cfg_reg.base_length      <= BASE_LENGTH_RST;
            cfg_reg.ext_bytes        <= '0;
            cfg_reg.root_entry_count <= ROOT_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NAME_BASE:   cfg_reg.name_base        <= cfg_data;
                CFG_BASE_LENGTH: cfg_reg.base_length      <= cfg_data[3:0];
                CFG_EXT_BYTES:   cfg_reg.ext_bytes        <= cfg_data[23:0];
                CFG_ROOT_COUNT:  cfg_reg.root_entry_count <= cfg_data[15:0];
                default:         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Input register; the scan step fires when the result slot is free
    assign step       = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    frds_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .emit  (emit),
        .res   (res)
    );

    // Result register
    assign result_valid_next = step ? emit : (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[dv/fat12_root_dir_search_test.sv]
// ----------------------------------------------------------------------------
// fat12_root_dir_search_test
// Self-checking bench for the FAT12 root directory search. Directory bytes
// are pushed one per transfer with random gaps, and results are drained with
// random backpressure. A behavioral scan of the same byte stream predicts
// each outcome, and every result transfer is compared field by field.
// Directed entries cover every outcome kind and the configuration extremes.
// Random phases then mix well-formed entries with noise and broken entries.
// ----------------------------------------------------------------------------
module fat12_root_dir_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import frds_pkg::*;

    // Name and extension encodings, byte 0 in the low bits
    localparam logic [63:0] NAME_README  = 64'h2020_454D_4441_4552;  // "README  "
    localparam logic [63:0] NAME_READMXY = 64'h5958_454D_4441_4552;  // "READMEXY"
    localparam logic [63:0] NAME_OTHER   = 64'h2045_5245_4854_4F4E;  // "NOTHERE "
    localparam logic [23:0] EXT_TXT      = 24'h54_58_54;
    localparam logic [23:0] EXT_TXU      = 24'h55_58_54;
    localparam logic [23:0] EXT_BIN      = 24'h4E_49_42;

    localparam int RAND_BYTES   = 750;
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    in_t         item;
    logic        result_valid;
    logic        result_ready;
    out_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // Expected outcomes, oldest first
    out_t dir_outcomes[$];
    int   fail_count = 0;
    int   scanned_bytes = 0;
    bit   steady = 1'b0;

    // Predictor copy of the configuration
    logic [63:0] want_name;
    logic [3:0]  want_len;
    logic [23:0] want_ext;
    logic [15:0] root_count;

    // Predictor copy of the scan state
    logic [4:0]  scan_pos;
    logic [15:0] scan_entry;
    logic [7:0]  entry_lead;
    bit          name_ok;
    logic [15:0] cap_cluster;
    logic [31:0] cap_size;
    bit          scan_done;

    fat12_root_dir_search dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_name_char();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(8'h41, 8'h5A));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int compared_len();
        return (want_len > BASE_MAX) ? int'(BASE_MAX) : int'(want_len);
    endfunction

    function automatic void restart_scan();
        scan_pos    = '0;
        scan_entry  = '0;
        entry_lead  = '0;
        name_ok     = 1'b1;
        cap_cluster = '0;
        cap_size    = '0;
        scan_done   = 1'b0;
    endfunction

    function automatic void post_outcome(logic [2:0] st, logic [15:0] cl, logic [31:0] sz);
        out_t r;
        r.status        = st;
        r.start_cluster = cl;
        r.file_size     = sz;
        r.entry_index   = scan_entry;
        dir_outcomes.push_back(r);
    endfunction

    // Advance the predicted scan by one accepted directory byte
    function automatic void scan_dir_byte(logic [7:0] b, logic rs);
        int searched;
        int pos;
        searched = (int'(root_count) / ENTRIES_PER_SECTOR) * ENTRIES_PER_SECTOR;
        if (rs)
            restart_scan();
        if (scan_done)
            return;
        scanned_bytes++;
        pos = scan_pos;

        // first byte: range bound, end marker, then open a new entry
        if (pos == 0) begin
            if (int'(scan_entry) >= searched) begin
                scan_done = 1'b1;
                post_outcome(ST_EXHAUSTED, '0, '0);
                return;
            end
            if (b == MARK_END) begin
                scan_done = 1'b1;
                post_outcome(ST_END, '0, '0);
                return;
            end
            entry_lead  = b;
            name_ok     = 1'b1;
            cap_cluster = '0;
            cap_size    = '0;
        end

        // name compare and field capture
        if (pos < 8) begin
            if (pos < compared_len() && b != want_name[8*pos +: 8])
                name_ok = 1'b0;
        end
        else if (pos < 11) begin
            if (b != want_ext[8*(pos-8) +: 8])
                name_ok = 1'b0;
        end
        else if (pos == 26)
            cap_cluster[7:0] = b;
        else if (pos == 27)
            cap_cluster[15:8] = b;
        else if (pos >= 28)
            cap_size[8*(pos-28) +: 8] = b;

        if (pos + 1 < ENTRY_BYTES) begin
            scan_pos = 5'(pos + 1);
            return;
        end

        // last byte of the entry: report it
        scan_pos = '0;
        if (entry_lead != MARK_DELETED && name_ok) begin
            scan_done = 1'b1;
            post_outcome(ST_FOUND, cap_cluster, cap_size);
        end
        else if (int'(scan_entry) + 1 >= searched) begin
            scan_done = 1'b1;
            post_outcome(ST_EXHAUSTED, '0, '0);
        end
        else begin
            post_outcome((entry_lead == MARK_DELETED) ? ST_DELETED : ST_NO_MATCH, '0, '0);
            scan_entry = scan_entry + 16'd1;
        end
    endfunction

    // One directory byte transfer
    task automatic push_dir_byte(input logic [7:0] b, input logic rs);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid     = 1'b1;
        item.data_byte = b;
        item.restart   = rs;
        do
            @(posedge clk);
        while (!item_ready);
        scan_dir_byte(b, rs);
    endtask

    function automatic logic [255:0] build_entry(logic [63:0] nm, logic [23:0] ex,
                                                 logic [15:0] cl, logic [31:0] sz);
        logic [255:0] e;
        int k;
        e = '0;
        e[63:0]  = nm;
        e[87:64] = ex;
        for (k = 11; k < 26; k++)
            e[8*k +: 8] = 8'($urandom_range(0, 255));
        e[223:208] = cl;
        e[255:224] = sz;
        return e;
    endfunction

    // Send the first nbytes of an entry; restart rides on byte 0
    task automatic push_entry(input logic [255:0] e, input logic rs, input int nbytes);
        int k;
        for (k = 0; k < nbytes; k++)
            push_dir_byte(e[8*k +: 8], (k == 0) ? rs : 1'b0);
    endtask

    // Stop sending, wait for every expected result, then let the pipe empty
    task automatic settle_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (dir_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_NAME_BASE:   want_name  = data;
            CFG_BASE_LENGTH: want_len   = data[3:0];
            CFG_EXT_BYTES:   want_ext   = data[23:0];
            CFG_ROOT_COUNT:  root_count = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Reset configuration, no restart on the first byte
    task automatic test_stream_without_restart();
        push_entry(build_entry(NAME_OTHER, EXT_BIN, 16'h0002, 32'h0000_0100), 1'b0, 32);
        push_dir_byte(MARK_END, 1'b0);
        // concluded: these are dropped
        push_dir_byte(8'hFF, 1'b0);
        push_dir_byte(8'h00, 1'b0);
        settle_idle();
    endtask

    // Deleted, mismatched extension, then a loose base name match
    task automatic test_entry_outcomes();
        write_reg(CFG_NAME_BASE, NAME_README);
        write_reg(CFG_BASE_LENGTH, 64'd6);
        write_reg(CFG_EXT_BYTES, {40'd0, EXT_TXT});
        write_reg(CFG_ROOT_COUNT, 64'd224);
        push_entry(build_entry({NAME_README[63:8], MARK_DELETED}, EXT_TXT, 16'h1234,
                               32'h55), 1'b1, 32);
        push_entry(build_entry(NAME_README, EXT_TXU, 16'h0003, 32'h10), 1'b0, 32);
        push_entry(build_entry(NAME_READMXY, EXT_TXT, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, 32);
        push_dir_byte(8'h52, 1'b0);
        push_dir_byte(8'hE5, 1'b0);
        settle_idle();
    endtask

    // All-ones name and extension, base length above eight, widest range
    task automatic test_extreme_config();
        write_reg(CFG_NAME_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_BASE_LENGTH, 64'd15);
        write_reg(CFG_EXT_BYTES, 64'hFF_FFFF);
        write_reg(CFG_ROOT_COUNT, 64'hFFFF);
        push_entry(build_entry(64'hFEFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 16'h0001, 32'h1),
                   1'b1, 32);
        push_entry(build_entry(64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 16'h0000, 32'h0),
                   1'b0, 32);
        settle_idle();
    endtask

    // Range below one sector: the first byte already exhausts the search
    task automatic test_empty_range();
        write_reg(CFG_BASE_LENGTH, 64'd0);
        write_reg(CFG_ROOT_COUNT, 64'd15);
        push_dir_byte(8'h41, 1'b1);
        push_dir_byte(8'h41, 1'b0);
        settle_idle();
        write_reg(CFG_ROOT_COUNT, 64'd0);
        push_dir_byte(MARK_END, 1'b1);
        settle_idle();
    endtask

    // Random configurations with mostly well-formed directory entries
    task automatic test_random_directory();
        int start_bytes;
        int n_entries;
        int k;
        int kind;
        int r;
        int part;
        int j;
        bit first;
        bit exhaust;
        bit realign;
        bit held_once;
        logic [63:0] nm;
        logic [15:0] cnt;
        start_bytes   = scanned_bytes;
        first     = 1'b1;
        held_once = 1'b0;
        while (scanned_bytes - start_bytes < RAND_BYTES) begin
            settle_idle();
            steady  = ($urandom_range(0, 4) == 0);
            exhaust = ($urandom_range(0, 6) == 0);

            // new settings, a random subset of registers
            if (first || $urandom_range(0, 1)) begin
                for (j = 0; j < 8; j++)
                    nm[8*j +: 8] = pick_name_char();
                write_reg(CFG_NAME_BASE, nm);
            end
            if (first || $urandom_range(0, 1))
                write_reg(CFG_BASE_LENGTH, ($urandom_range(0, 3) == 0) ?
                          64'($urandom_range(0, 15)) : 64'($urandom_range(1, 8)));
            if (first || $urandom_range(0, 1))
                write_reg(CFG_EXT_BYTES, {40'd0, pick_name_char(), pick_name_char(),
                                          pick_name_char()});
            if (first || exhaust || $urandom_range(0, 1)) begin
                r = $urandom_range(0, 99);
                if (exhaust || r < 30)
                    cnt = 16'($urandom_range(16, 31));
                else if (r < 40)
                    cnt = 16'($urandom_range(0, 15));
                else if (r < 85)
                    cnt = 16'($urandom_range(32, 255));
                else
                    cnt = 16'($urandom_range(0, 65535));
                write_reg(CFG_ROOT_COUNT, {48'd0, cnt});
            end
            first = 1'b0;

            n_entries = exhaust ? 17 : $urandom_range(1, 10);
            realign   = 1'b1;
            for (k = 0; k < n_entries; k++) begin
                // once, hold the sender until every result is back
                if (!held_once && k == 2) begin
                    settle_idle();
                    held_once = 1'b1;
                end
                kind = exhaust ? $urandom_range(0, 54) : $urandom_range(0, 99);
                if (kind < 40)
                    push_entry(build_entry(
                        {pick_name_char(), pick_name_char(), pick_name_char(),
                         pick_name_char(), pick_name_char(), pick_name_char(),
                         pick_name_char(), pick_name_char()},
                        {pick_name_char(), pick_name_char(), pick_name_char()},
                        16'($urandom), $urandom), realign || scan_done, 32);
                else if (kind < 55) begin
                    nm = want_name;
                    for (j = compared_len(); j < 8; j++)
                        nm[8*j +: 8] = pick_name_char();
                    nm[7:0] = MARK_DELETED;
                    push_entry(build_entry(nm, want_ext, 16'($urandom), $urandom),
                               realign || scan_done, 32);
                end
                else if (kind < 67) begin
                    nm = want_name;
                    for (j = compared_len(); j < 8; j++)
                        nm[8*j +: 8] = pick_name_char();
                    push_entry(build_entry(nm, want_ext, 16'($urandom), $urandom),
                               realign || scan_done, 32);
                end
                else if (kind < 72)
                    push_entry(build_entry({56'($urandom) << 8, MARK_END}, want_ext,
                                           16'($urandom), $urandom), realign || scan_done, 32);
                else if (kind < 82) begin
                    // loose bytes with an occasional restart
                    part = $urandom_range(1, 8);
                    for (j = 0; j < part; j++)
                        push_dir_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
                else if (kind < 90) begin
                    // entry cut short
                    nm = want_name;
                    push_entry(build_entry(nm, want_ext, 16'($urandom), $urandom),
                               realign || scan_done, $urandom_range(1, 31));
                end
                else
                    push_entry({$urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom},
                               realign || scan_done, 32);
                realign = (kind >= 72 && kind < 90);
            end
        end
        steady = 1'b0;
    endtask

    task automatic report_field(input string what, input logic [31:0] exp,
                                input logic [31:0] act);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp, act);
        fail_count++;
    endtask

    // Compare each result transfer with the oldest expected outcome
    always @(posedge clk) begin
        out_t exp;
        if (rst_n && result_valid && result_ready) begin
            if (dir_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                fail_count++;
            end
            else begin
                exp = dir_outcomes.pop_front();
                if (result.status !== exp.status)
                    report_field("status", 32'(exp.status), 32'(result.status));
                if (result.start_cluster !== exp.start_cluster)
                    report_field("start_cluster", 32'(exp.start_cluster),
                                 32'(result.start_cluster));
                if (result.file_size !== exp.file_size)
                    report_field("file_size", exp.file_size, result.file_size);
                if (result.entry_index !== exp.entry_index)
                    report_field("entry_index", 32'(exp.entry_index), 32'(result.entry_index));
            end
        end
    end

    // Result side backpressure
    initial begin
        int hold;
        hold = 0;
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (steady)
                result_ready = 1'b1;
            else if (hold > 0)
                hold--;
            else begin
                result_ready = ($urandom_range(0, 99) < 70);
                hold = pick_gap();
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        want_name  = '0;
        want_len   = BASE_LENGTH_RST;
        want_ext   = '0;
        root_count = ROOT_COUNT_RST;
        restart_scan();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_stream_without_restart();
        test_entry_outcomes();
        test_extreme_config();
        test_empty_range();
        test_random_directory();
        settle_idle();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
